@@ src/apf_pkg.sv @@
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types and constants of the articulation point finder.
// ----------------------------------------------------------------------------
package apf_pkg;

   localparam int MAX_NODES_DEF   = 1024;
   localparam int MAX_ENTRIES_DEF = 8192;
   localparam int NODE_W          = 10;
   localparam int COUNT_W         = 11;
   localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       is_articulation;
   } rsp_type;

endpackage

@@ src/articulation_point_finder.sv @@
// ----------------------------------------------------------------------------
// articulation_point_finder
// Cut vertex search over an undirected graph held in a linked adjacency store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the node memory before it takes the first
// transaction. An edge add reads and links node a, then node b, a query
// reads its node, and each then posts the result; an unknown kind, or an add
// or a query rejected for range or a full store, goes straight to posting.
// A run first sweeps all MAX_NODES node entries to clear their flags, then
// scans the nodes in use and walks the search one stored edge entry at a
// time, retreating through parent links and closing each root. The node
// memory is read through a register. The per-node search state (list heads,
// discovery and low-link values, flags, edge cursors and parent links) lives
// in the node memory; edges live in the entry memory.
module articulation_point_finder #(
   parameter int MAX_NODES   = apf_pkg::MAX_NODES_DEF,
   parameter int MAX_ENTRIES = apf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  apf_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output apf_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_enable,
   input  logic [apf_pkg::COUNT_W-1:0]  csr_write_data
);

   localparam int NAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCNT = NAW + 1;
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int EAW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ECW  = $clog2(MAX_ENTRIES + 1);

   typedef struct packed {
      logic           hv;
      logic [EAW-1:0] head;
      logic           vis;
      logic           cut;
      logic [NAW-1:0] disc;
      logic [NAW-1:0] low;
      logic           has;
      logic [EAW-1:0] cur;
      logic [NAW-1:0] par;
   } node_rec_type;

   typedef struct packed {
      logic [NAW-1:0] target;
      logic           nv;
      logic [EAW-1:0] next;
   } entry_rec_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_ADD_A, S_ADD_B0, S_ADD_B, S_QRY, S_CLR,
      S_SCAN, S_SCAN_W, S_STEP, S_EDGE, S_NODE, S_POP, S_RESP
   } state_type;

   node_rec_type  node_mem [MAX_NODES];
   entry_rec_type entry_mem [MAX_ENTRIES];

   state_type                   state_ff, state_in;
   logic [NCNT-1:0]             idx_ff, idx_in;
   logic                        pend_ff, pend_in;
   logic [NAW-1:0]              waddr_ff, waddr_in;
   logic [NAW-1:0]              v_ff, v_in;
   logic [NAW-1:0]              r_ff, r_in;
   logic [NAW-1:0]              k_ff, k_in;
   logic [1:0]                  rc_ff, rc_in;
   logic [NAW-1:0]              w_ff, w_in;
   logic [NAW-1:0]              a_ff, a_in;
   logic [NAW-1:0]              b_ff, b_in;
   logic [ECW-1:0]              cnt_ff, cnt_in;
   node_rec_type                cache_ff, cache_in;
   apf_pkg::rsp_type            res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   apf_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic [apf_pkg::COUNT_W-1:0] node_count_ff;

   node_rec_type  node_rd_ff;
   entry_rec_type entry_rd_ff;
   logic [NAW-1:0] node_ra, node_wa;
   logic           node_we;
   node_rec_type   node_wd;
   logic [EAW-1:0] entry_ra, entry_wa;
   logic           entry_we;
   entry_rec_type  entry_wd;

   logic [NCW-1:0] n_use;

   assign n_use = (32'(node_count_ff) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_wa] <= entry_wd;
      end
      entry_rd_ff <= entry_mem[entry_ra];
   end

   always_comb begin
      node_rec_type  rec;
      node_rec_type  wrec;
      entry_rec_type ent;

      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      waddr_in     = waddr_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      rc_in        = rc_ff;
      w_in         = w_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      cache_in     = cache_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      node_ra      = '0;
      node_we      = 1'b0;
      node_wa      = '0;
      node_wd      = node_rd_ff;
      entry_ra     = '0;
      entry_we     = 1'b0;
      entry_wa     = '0;
      entry_wd     = '0;
      rec          = node_rd_ff;
      wrec         = (w_ff == v_ff) ? cache_ff : node_rd_ff;
      ent          = entry_rd_ff;

      // drop the posted result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            node_we = 1'b1;
            node_wa = idx_ff[NAW-1:0];
            node_wd = '0;
            if (idx_ff == NCNT'(MAX_NODES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + NCNT'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               a_in     = NAW'(req_data.node_a);
               b_in     = NAW'(req_data.node_b);
               res_in   = '{status: 2'(apf_pkg::STAT_OK), is_articulation: 1'b0};
               state_in = S_RESP;
               unique case (req_data.kind)
                  2'(apf_pkg::KIND_ADD): begin
                     if (32'(req_data.node_a) >= 32'(n_use) ||
                         32'(req_data.node_b) >= 32'(n_use)) begin
                        res_in.status = 2'(apf_pkg::STAT_RANGE);
                     end else if (32'(cnt_ff) > MAX_ENTRIES - 2) begin
                        res_in.status = 2'(apf_pkg::STAT_FULL);
                     end else begin
                        node_ra  = NAW'(req_data.node_a);
                        state_in = S_ADD_A;
                     end
                  end
                  2'(apf_pkg::KIND_RUN): begin
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_CLR;
                  end
                  2'(apf_pkg::KIND_QUERY): begin
                     if (32'(req_data.node_a) >= 32'(n_use)) begin
                        res_in.status = 2'(apf_pkg::STAT_RANGE);
                     end else begin
                        node_ra  = NAW'(req_data.node_a);
                        state_in = S_QRY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_A: begin
            entry_we = 1'b1;
            entry_wa = cnt_ff[EAW-1:0];
            entry_wd = '{target: b_ff, nv: rec.hv, next: rec.head};
            node_we  = 1'b1;
            node_wa  = a_ff;
            node_wd  = rec;
            node_wd.hv   = 1'b1;
            node_wd.head = cnt_ff[EAW-1:0];
            cnt_in   = cnt_ff + ECW'(1);
            state_in = S_ADD_B0;
         end
         S_ADD_B0: begin
            node_ra  = b_ff;
            state_in = S_ADD_B;
         end
         S_ADD_B: begin
            entry_we = 1'b1;
            entry_wa = cnt_ff[EAW-1:0];
            entry_wd = '{target: a_ff, nv: rec.hv, next: rec.head};
            node_we  = 1'b1;
            node_wa  = b_ff;
            node_wd  = rec;
            node_wd.hv   = 1'b1;
            node_wd.head = cnt_ff[EAW-1:0];
            cnt_in   = cnt_ff + ECW'(1);
            state_in = S_RESP;
         end
         S_QRY: begin
            res_in.is_articulation = rec.cut;
            state_in = S_RESP;
         end
         S_CLR: begin
            // read one entry, write back the one before with flags cleared
            if (pend_ff) begin
               node_we = 1'b1;
               node_wa = waddr_ff;
               node_wd = rec;
               node_wd.vis = 1'b0;
               node_wd.cut = 1'b0;
            end
            if (idx_ff != NCNT'(MAX_NODES)) begin
               node_ra  = idx_ff[NAW-1:0];
               waddr_in = idx_ff[NAW-1:0];
               pend_in  = 1'b1;
               idx_in   = idx_ff + NCNT'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (32'(idx_ff) >= 32'(n_use)) begin
               state_in = S_RESP;
            end else begin
               node_ra  = idx_ff[NAW-1:0];
               state_in = S_SCAN_W;
            end
         end
         S_SCAN_W: begin
            if (rec.vis) begin
               idx_in   = idx_ff + NCNT'(1);
               state_in = S_SCAN;
            end else begin
               r_in  = idx_ff[NAW-1:0];
               v_in  = idx_ff[NAW-1:0];
               k_in  = NAW'(1);
               rc_in = '0;
               cache_in      = rec;
               cache_in.vis  = 1'b1;
               cache_in.cut  = 1'b0;
               cache_in.disc = '0;
               cache_in.low  = '0;
               cache_in.has  = rec.hv;
               cache_in.cur  = rec.head;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (cache_ff.has) begin
               entry_ra = cache_ff.cur;
               state_in = S_EDGE;
            end else if (v_ff == r_ff) begin
               node_we = 1'b1;
               node_wa = v_ff;
               node_wd = cache_ff;
               node_wd.cut = (rc_ff == 2'd2);
               idx_in   = idx_ff + NCNT'(1);
               state_in = S_SCAN;
            end else begin
               node_we  = 1'b1;
               node_wa  = v_ff;
               node_wd  = cache_ff;
               node_ra  = cache_ff.par;
               state_in = S_POP;
            end
         end
         S_EDGE: begin
            cache_in.cur = ent.next;
            cache_in.has = ent.nv;
            w_in = ent.target;
            if (32'(ent.target) >= 32'(n_use)) begin
               state_in = S_STEP;
            end else begin
               node_ra  = ent.target;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (!wrec.vis) begin
               if (v_ff == r_ff && rc_ff != 2'd2) begin
                  rc_in = rc_ff + 2'd1;
               end
               // park the current node, descend into the new one
               node_we = 1'b1;
               node_wa = v_ff;
               node_wd = cache_ff;
               cache_in      = wrec;
               cache_in.vis  = 1'b1;
               cache_in.disc = k_ff;
               cache_in.low  = k_ff;
               cache_in.has  = wrec.hv;
               cache_in.cur  = wrec.head;
               cache_in.par  = v_ff;
               k_in = k_ff + NAW'(1);
               v_in = w_ff;
            end else if ((v_ff == r_ff || w_ff != cache_ff.par) &&
                         wrec.disc < cache_ff.low) begin
               cache_in.low = wrec.disc;
            end
            state_in = S_STEP;
         end
         S_POP: begin
            cache_in = rec;
            if (cache_ff.low < rec.low) begin
               cache_in.low = cache_ff.low;
            end
            if (cache_ff.par != r_ff && rec.disc <= cache_ff.low) begin
               cache_in.cut = 1'b1;
            end
            v_in     = cache_ff.par;
            state_in = S_STEP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rc_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= apf_pkg::NODE_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rc_ff        <= rc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            node_count_ff <= csr_write_data;
         end
      end
      waddr_ff    <= waddr_in;
      v_ff        <= v_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      w_ff        <= w_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      cache_ff    <= cache_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ src/apf_checker.sv @@
// ----------------------------------------------------------------------------
// apf_checker
// Port-level checks of the articulation point finder.
// ----------------------------------------------------------------------------
module apf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input apf_pkg::rsp_type rsp_data
);

   // hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_articulation |->
         rsp_data.status == 2'(apf_pkg::STAT_OK))
      else $error("flag set on a failed transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == 2'(apf_pkg::STAT_OK) ||
                    rsp_data.status == 2'(apf_pkg::STAT_FULL) ||
                    rsp_data.status == 2'(apf_pkg::STAT_RANGE))
      else $error("undefined status code");

   // the node sweep after reset keeps the request side stalled
   assert property (@(posedge clock)
      !reset && $past(reset) |-> req_stall)
      else $error("request taken during the reset sweep");

endmodule

bind articulation_point_finder apf_checker u_apf_checker (.*);
